### hdl/cqs_pkg.sv
package cqs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_SEVEN     = 8'h37;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_OCT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // one result word
    typedef struct packed {
        logic [7:0] value;
        kind_t      kind;
    } result_t;

    // what one input word leaves for the back end: one or two results
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    // simple escape lookup: bit 8 set when the byte is a known escape
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h5c:   r = {1'b1, 8'h5c};
            8'h22:   r = {1'b1, 8'h22};
            8'h6e:   r = {1'b1, 8'h0a};
            8'h74:   r = {1'b1, 8'h09};
            8'h72:   r = {1'b1, 8'h0d};
            8'h61:   r = {1'b1, 8'h07};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0c};
            8'h76:   r = {1'b1, 8'h0b};
            8'h3f:   r = {1'b1, 8'h3f};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
    endfunction

endpackage

### hdl/cqs_front.sv
module cqs_front
    import cqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic       end_of_text,
    input  logic [7:0] data_byte,
    output logic       push,
    output entry_t     push_entry
);

    mode_t      mode_reg, mode_next;
    logic [7:0] accum_reg, accum_next;
    logic [1:0] count_reg, count_next;

    logic [7:0] digit;
    logic [7:0] accum_shift;
    logic [1:0] count_inc;
    logic [8:0] esc;

    assign digit       = data_byte - CHAR_ZERO;
    assign accum_shift = {accum_reg[4:0], digit[2:0]};
    assign count_inc   = count_reg + 2'd1;
    assign esc         = simple_escape(data_byte);

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        unique case (mode_reg)
            MODE_WAIT:
            begin
                if (!end_of_text && data_byte == CHAR_QUOTE)
                    mode_next = MODE_STR;
                else
                begin
                    mode_next  = MODE_WAIT;
                    accum_next = 8'd0;
                    count_next = 2'd0;
                end
            end
            MODE_STR:
            begin
                if (end_of_text || data_byte == CHAR_QUOTE)
                begin
                    mode_next  = MODE_WAIT;
                    accum_next = 8'd0;
                    count_next = 2'd0;
                end
                else if (data_byte == CHAR_BACKSLASH)
                    mode_next = MODE_ESC;
            end
            MODE_ESC:
            begin
                if (end_of_text)
                begin
                    mode_next  = MODE_WAIT;
                    accum_next = 8'd0;
                    count_next = 2'd0;
                end
                else if (esc[8])
                    mode_next = MODE_STR;
                else if (is_octal(data_byte))
                begin
                    mode_next  = MODE_OCT;
                    accum_next = {5'd0, digit[2:0]};
                    count_next = 2'd1;
                end
                else
                begin
                    mode_next  = MODE_WAIT;
                    accum_next = 8'd0;
                    count_next = 2'd0;
                end
            end
            MODE_OCT:
            begin
                accum_next = 8'd0;
                count_next = 2'd0;
                if (!end_of_text && is_octal(data_byte))
                begin
                    if (count_inc == 2'd3 || count_inc == 2'd0)
                        mode_next = MODE_STR;
                    else
                    begin
                        accum_next = accum_shift;
                        count_next = count_inc;
                    end
                end
                else if (end_of_text || data_byte == CHAR_QUOTE)
                    mode_next = MODE_WAIT;
                else if (data_byte == CHAR_BACKSLASH)
                    mode_next = MODE_ESC;
                else
                    mode_next = MODE_STR;
            end
            default: mode_next = MODE_WAIT;
        endcase
    end

    // results of this word
    always_comb
    begin
        logic   any;
        entry_t e;
        any = 1'b0;
        e   = '0;
        unique case (mode_reg)
            MODE_WAIT:
            begin
                if (end_of_text || data_byte != CHAR_QUOTE)
                begin
                    any           = 1'b1;
                    e.first.kind  = KIND_ERROR;
                end
            end
            MODE_STR:
            begin
                if (end_of_text)
                begin
                    any          = 1'b1;
                    e.first.kind = KIND_ERROR;
                end
                else if (data_byte == CHAR_QUOTE)
                begin
                    any          = 1'b1;
                    e.first.kind = KIND_CLOSE;
                end
                else if (data_byte != CHAR_BACKSLASH)
                begin
                    any           = 1'b1;
                    e.first.value = data_byte;
                    e.first.kind  = KIND_BYTE;
                end
            end
            MODE_ESC:
            begin
                any = 1'b1;
                if (end_of_text)
                    e.first.kind = KIND_ERROR;
                else if (esc[8])
                begin
                    e.first.value = esc[7:0];
                    e.first.kind  = KIND_BYTE;
                end
                else if (is_octal(data_byte))
                    any = 1'b0;
                else
                    e.first.kind = KIND_ERROR;
            end
            MODE_OCT:
            begin
                if (!end_of_text && is_octal(data_byte))
                begin
                    if (count_inc == 2'd3 || count_inc == 2'd0)
                    begin
                        any           = 1'b1;
                        e.first.value = accum_shift;
                        e.first.kind  = KIND_BYTE;
                    end
                end
                else
                begin
                    // octal byte, then the terminating byte handled in the string
                    any           = 1'b1;
                    e.first.value = accum_reg;
                    e.first.kind  = KIND_BYTE;
                    if (end_of_text)
                    begin
                        e.two         = 1'b1;
                        e.second.kind = KIND_ERROR;
                    end
                    else if (data_byte == CHAR_QUOTE)
                    begin
                        e.two         = 1'b1;
                        e.second.kind = KIND_CLOSE;
                    end
                    else if (data_byte != CHAR_BACKSLASH)
                    begin
                        e.two          = 1'b1;
                        e.second.value = data_byte;
                        e.second.kind  = KIND_BYTE;
                    end
                end
            end
            default: any = 1'b0;
        endcase
        push       = take && any;
        push_entry = e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_WAIT;
            accum_reg <= 8'd0;
            count_reg <= 2'd0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/cqs_queue.sv
module cqs_queue
    import cqs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output head_t  head
);

    entry_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

### hdl/cqs_back.sv
module cqs_back
    import cqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  head_t      head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       out_last
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    kind_t      kind_reg, kind_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic       load;

    assign load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        kind_next   = kind_reg;
        last_next   = last_reg;
        second_next = second_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = head.valid;
            if (head.valid)
            begin
                if (!second_reg)
                begin
                    byte_next   = head.entry.first.value;
                    kind_next   = head.entry.first.kind;
                    last_next   = !head.entry.two;
                    second_next = head.entry.two;
                    pop         = !head.entry.two;
                end
                else
                begin
                    byte_next   = head.entry.second.value;
                    kind_next   = head.entry.second.kind;
                    last_next   = 1'b1;
                    second_next = 1'b0;
                    pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

### hdl/c_quoted_string_unescaper_core.sv
// path: each result word is written to a queue slot, then to the output register
// throughput: one input word per cycle while the queue is not full; an input with two results
//   gives two output words; the four-entry parser-to-output queue absorbs the difference
// reset: rst_n is asynchronous, active low; it returns the parser to waiting for an opening
//   quote, empties the queue and drops the output valid
module c_quoted_string_unescaper_core
    import cqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] s_axis_tuser,   // [0] req_type (1 = end of text)
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] result_kind
    output logic       m_axis_tlast    // last_of_run
);

    logic   full;
    logic   take;
    logic   push;
    entry_t push_entry;
    logic   pop;
    head_t  head;

    // input side stalls only when the queue is full, never on the output side directly
    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;

    // parser: keeps the decode state and turns each word into zero, one or two results
    cqs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .end_of_text (s_axis_tuser[0]),
        .data_byte   (s_axis_tdata),
        .push        (push),
        .push_entry  (push_entry)
    );

    // short queue of result entries between parser and output
    cqs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head       (head)
    );

    // output stage: one registered word per cycle if ready; an entry's second result follows
    cqs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
